@@ hdl/vsar_pkg.sv @@
// Shared types, op codes and constants for the video scroll address registers.
package vsar_pkg;

   localparam int unsigned OP_WIDTH   = 4;
   localparam int unsigned DATA_WIDTH = 8;
   localparam int unsigned ADDR_WIDTH = 15;
   localparam int unsigned OUT_WIDTH  = 14;

   localparam logic [OP_WIDTH-1:0] OP_CTRL_WRITE   = 4'd0;
   localparam logic [OP_WIDTH-1:0] OP_SCROLL_WRITE = 4'd1;
   localparam logic [OP_WIDTH-1:0] OP_ADDR_WRITE   = 4'd2;
   localparam logic [OP_WIDTH-1:0] OP_DATA_ACCESS  = 4'd3;
   localparam logic [OP_WIDTH-1:0] OP_STATUS_READ  = 4'd4;
   localparam logic [OP_WIDTH-1:0] OP_INC_X        = 4'd5;
   localparam logic [OP_WIDTH-1:0] OP_INC_Y        = 4'd6;
   localparam logic [OP_WIDTH-1:0] OP_COPY_H       = 4'd7;
   localparam logic [OP_WIDTH-1:0] OP_COPY_V       = 4'd8;
   localparam logic [OP_WIDTH-1:0] OP_NONE         = 4'd9;

   localparam logic [4:0] COARSE_LAST     = 5'd31;
   localparam logic [4:0] COARSE_Y_ROWEND = 5'd29;
   localparam logic [2:0] FINE_LAST       = 3'd7;
   localparam logic [ADDR_WIDTH-1:0] ROW_STEP = 15'd32;
   localparam logic [ADDR_WIDTH-1:0] COL_STEP = 15'd1;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [DATA_WIDTH-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] vram_address;
      logic [OUT_WIDTH-1:0] tile_fetch_address;
      logic [OUT_WIDTH-1:0] attribute_fetch_address;
      logic [2:0]           attribute_shift;
      logic [2:0]           fine_y;
      logic [2:0]           fine_x;
      logic                 write_toggle;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] current_address;
      logic [ADDR_WIDTH-1:0] temporary_address;
      logic [2:0]            fine_x_scroll;
      logic                  second_write;
      logic                  step_by_row;
   } state_type;

endpackage

@@ hdl/vsar_channels.sv @@
// Valid/ready channel interfaces for request and response items.
interface vsar_req_if;
   logic                             valid;
   logic                             ready;
   logic [vsar_pkg::OP_WIDTH-1:0]    op;
   logic [vsar_pkg::DATA_WIDTH-1:0]  data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface vsar_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [vsar_pkg::OUT_WIDTH-1:0]  vram_address;
   logic [vsar_pkg::OUT_WIDTH-1:0]  tile_fetch_address;
   logic [vsar_pkg::OUT_WIDTH-1:0]  attribute_fetch_address;
   logic [2:0]                      attribute_shift;
   logic [2:0]                      fine_y;
   logic [2:0]                      fine_x;
   logic                            write_toggle;

   modport source (output valid, output vram_address, output tile_fetch_address,
                   output attribute_fetch_address, output attribute_shift,
                   output fine_y, output fine_x, output write_toggle, input ready);
   modport sink   (input valid, input vram_address, input tile_fetch_address,
                   input attribute_fetch_address, input attribute_shift,
                   input fine_y, input fine_x, input write_toggle, output ready);
endinterface

@@ hdl/vsar_update.sv @@
// Next-state and result logic for one op applied to the scroll registers.
module vsar_update (
   input  vsar_pkg::req_type   item,
   input  vsar_pkg::state_type state_cur,
   output vsar_pkg::state_type state_nxt,
   output vsar_pkg::rsp_type   result
);

   logic [vsar_pkg::ADDR_WIDTH-1:0] v;
   logic [vsar_pkg::ADDR_WIDTH-1:0] t;
   logic [vsar_pkg::ADDR_WIDTH-1:0] v_inc_x;
   logic [vsar_pkg::ADDR_WIDTH-1:0] v_inc_y;
   logic [vsar_pkg::DATA_WIDTH-1:0] d;

   assign v = state_cur.current_address;
   assign t = state_cur.temporary_address;
   assign d = item.data_byte;

   // result comes from the address held before this item
   assign result.vram_address            = v[13:0];
   assign result.tile_fetch_address      = {2'b10, v[11:0]};
   assign result.attribute_fetch_address = {2'b10, v[11:10], 4'b1111, v[9:7], v[4:2]};
   assign result.attribute_shift         = {v[6], v[1], 1'b0};
   assign result.fine_y                  = v[14:12];
   assign result.fine_x                  = state_cur.fine_x_scroll;
   assign result.write_toggle            = state_cur.second_write;

   // coarse X: wrap at 31 into the other horizontal nametable
   always_comb begin
      v_inc_x = v;
      if (v[4:0] == vsar_pkg::COARSE_LAST) begin
         v_inc_x[4:0] = 5'd0;
         v_inc_x[10]  = ~v[10];
      end else begin
         v_inc_x[4:0] = v[4:0] + 5'd1;
      end
   end

   // vertical: fine Y first, then coarse Y with row 29 / row 31 wraps
   always_comb begin
      v_inc_y = v;
      if (v[14:12] != vsar_pkg::FINE_LAST) begin
         v_inc_y[14:12] = v[14:12] + 3'd1;
      end else begin
         v_inc_y[14:12] = 3'd0;
         if (v[9:5] == vsar_pkg::COARSE_Y_ROWEND) begin
            v_inc_y[9:5] = 5'd0;
            v_inc_y[11]  = ~v[11];
         end else if (v[9:5] == vsar_pkg::COARSE_LAST) begin
            v_inc_y[9:5] = 5'd0;
         end else begin
            v_inc_y[9:5] = v[9:5] + 5'd1;
         end
      end
   end

   always_comb begin
      state_nxt = state_cur;
      case (item.op)
         vsar_pkg::OP_CTRL_WRITE: begin
            state_nxt.temporary_address[11:10] = d[1:0];
            state_nxt.step_by_row              = d[2];
         end
         vsar_pkg::OP_SCROLL_WRITE: begin
            if (!state_cur.second_write) begin
               state_nxt.temporary_address[4:0] = d[7:3];
               state_nxt.fine_x_scroll          = d[2:0];
            end else begin
               state_nxt.temporary_address[9:5]   = d[7:3];
               state_nxt.temporary_address[14:12] = d[2:0];
            end
            state_nxt.second_write = ~state_cur.second_write;
         end
         vsar_pkg::OP_ADDR_WRITE: begin
            if (!state_cur.second_write) begin
               state_nxt.temporary_address = {1'b0, d[5:0], t[7:0]};
            end else begin
               state_nxt.temporary_address = {t[14:8], d};
               state_nxt.current_address   = {t[14:8], d};
            end
            state_nxt.second_write = ~state_cur.second_write;
         end
         vsar_pkg::OP_DATA_ACCESS: begin
            state_nxt.current_address = v + (state_cur.step_by_row ? vsar_pkg::ROW_STEP
                                                                   : vsar_pkg::COL_STEP);
         end
         vsar_pkg::OP_STATUS_READ: begin
            state_nxt.second_write = 1'b0;
         end
         vsar_pkg::OP_INC_X: begin
            state_nxt.current_address = v_inc_x;
         end
         vsar_pkg::OP_INC_Y: begin
            state_nxt.current_address = v_inc_y;
         end
         vsar_pkg::OP_COPY_H: begin
            state_nxt.current_address[10]  = t[10];
            state_nxt.current_address[4:0] = t[4:0];
         end
         vsar_pkg::OP_COPY_V: begin
            state_nxt.current_address[14:11] = t[14:11];
            state_nxt.current_address[9:5]   = t[9:5];
         end
         vsar_pkg::OP_NONE: begin
            state_nxt = state_cur;
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

@@ hdl/video_scroll_address_registers_unit.sv @@
// Top level: scroll and address registers with registered request and response items.
//
//   channel  dir  payload                                       handshake
//   req      in   op[3:0], data_byte[7:0]                        valid/ready
//   rsp      out  vram/tile/attribute address, shift, fine y/x,  valid/ready
//                 write_toggle
//
// Flow: an item is first held in the request register, then the op is
//   applied and its result lands in the response register.
// Throughput is one item per cycle while rsp does not stall.
// Reset (synchronous, active high) clears all scroll state and both valids.
// A stall on rsp holds the pending item in the request register and the
//   state untouched; req stays ready while that register is free or draining.
module video_scroll_address_registers_unit (
   input logic       clock,
   input logic       reset,
   vsar_req_if.sink  req,
   vsar_rsp_if.source rsp
);

   // request register
   logic                 req_valid_ff;
   vsar_pkg::req_type    req_item_ff;

   // scroll state
   vsar_pkg::state_type  state_ff;
   vsar_pkg::state_type  state_in;

   // response register
   logic                 rsp_valid_ff;
   vsar_pkg::rsp_type    rsp_item_ff;
   vsar_pkg::rsp_type    rsp_item_in;

   logic                 advance;

   // item moves to the response side when the output slot is free or emptying
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !req_valid_ff || advance;

   vsar_update u_update (
      .item      (req_item_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req.ready) begin
         req_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_item_ff.op        <= req.op;
         req_item_ff.data_byte <= req.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp.valid                   = rsp_valid_ff;
   assign rsp.vram_address            = rsp_item_ff.vram_address;
   assign rsp.tile_fetch_address      = rsp_item_ff.tile_fetch_address;
   assign rsp.attribute_fetch_address = rsp_item_ff.attribute_fetch_address;
   assign rsp.attribute_shift         = rsp_item_ff.attribute_shift;
   assign rsp.fine_y                  = rsp_item_ff.fine_y;
   assign rsp.fine_x                  = rsp_item_ff.fine_x;
   assign rsp.write_toggle            = rsp_item_ff.write_toggle;

   // a stalled response freezes the scroll state
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> $stable(state_ff))
      else $error("scroll state changed while response stalled");

   // every applied item produces a response from the pre-update address
   a_result_from_old_address: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid_ff &&
                   rsp_item_ff.vram_address == $past(state_ff.current_address[13:0])))
      else $error("response does not reflect address before update");

   // status read clears the write toggle
   a_status_clears_toggle: assert property (@(posedge clock) disable iff (reset)
      (advance && req_item_ff.op == vsar_pkg::OP_STATUS_READ) |=> !state_ff.second_write)
      else $error("write toggle not cleared by status read");

   // scroll and address writes flip the toggle
   a_write_flips_toggle: assert property (@(posedge clock) disable iff (reset)
      (advance && (req_item_ff.op == vsar_pkg::OP_SCROLL_WRITE ||
                   req_item_ff.op == vsar_pkg::OP_ADDR_WRITE))
      |=> (state_ff.second_write != $past(state_ff.second_write)))
      else $error("write toggle did not flip");

endmodule

@@ sim/video_scroll_address_registers_unit_tb.sv @@
// Self-checking testbench for the video scroll address registers unit.
`timescale 1ns / 100ps

module video_scroll_address_registers_unit_tb;

   // Op codes above OP_NONE are unused and must leave the registers alone.
   localparam logic [vsar_pkg::OP_WIDTH-1:0] OP_UNUSED_LOW  = 4'd10;
   localparam logic [vsar_pkg::OP_WIDTH-1:0] OP_UNUSED_HIGH = 4'd15;

   localparam int unsigned ITEM_TARGET   = 1600;  // counted items, ignored ops excluded
   localparam int unsigned CALM_TAIL     = 200;   // last items run without gaps or stalls
   localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
   localparam int unsigned DRAIN_CYCLES  = 8;     // extra settling wait after the last expected result

   // Tracks the scroll registers and holds the fetch results still owed by the block.
   class scroll_fetch_scoreboard;
      vsar_pkg::state_type   regs;
      vsar_pkg::rsp_type     expected_fetches[$];
      int unsigned           failures;

      function new();
         regs     = '0;
         failures = 0;
      endfunction

      // Result is taken from the registers as they stand before the op applies.
      function vsar_pkg::rsp_type fetch_view();
         logic [vsar_pkg::ADDR_WIDTH-1:0] v;
         vsar_pkg::rsp_type               r;
         v = regs.current_address;
         r.vram_address            = v[13:0];
         r.tile_fetch_address      = {2'b10, v[11:0]};
         r.attribute_fetch_address = {2'b10, v[11:10], 4'b1111, v[9:7], v[4:2]};
         r.attribute_shift         = {v[6], v[1], 1'b0};
         r.fine_y                  = v[14:12];
         r.fine_x                  = regs.fine_x_scroll;
         r.write_toggle            = regs.second_write;
         return r;
      endfunction

      // Address layout: [4:0] coarse X, [9:5] coarse Y, [10] NT X, [11] NT Y, [14:12] fine Y.
      function void apply_op(logic [vsar_pkg::OP_WIDTH-1:0] op,
                             logic [vsar_pkg::DATA_WIDTH-1:0] d);
         logic [vsar_pkg::ADDR_WIDTH-1:0] v;
         logic [vsar_pkg::ADDR_WIDTH-1:0] t;
         logic [4:0]                      row;
         v = regs.current_address;
         t = regs.temporary_address;
         case (op)
            vsar_pkg::OP_CTRL_WRITE: begin
               t[11:10]         = d[1:0];
               regs.step_by_row = d[2];
            end
            vsar_pkg::OP_SCROLL_WRITE: begin
               if (!regs.second_write) begin
                  t[4:0]             = d[7:3];
                  regs.fine_x_scroll = d[2:0];
               end else begin
                  t[9:5]   = d[7:3];
                  t[14:12] = d[2:0];
               end
               regs.second_write = ~regs.second_write;
            end
            vsar_pkg::OP_ADDR_WRITE: begin
               if (!regs.second_write) begin
                  t[13:8] = d[5:0];
                  t[14]   = 1'b0;
               end else begin
                  t[7:0] = d;
                  v      = t;
               end
               regs.second_write = ~regs.second_write;
            end
            vsar_pkg::OP_DATA_ACCESS:
               v = v + (regs.step_by_row ? vsar_pkg::ROW_STEP : vsar_pkg::COL_STEP);
            vsar_pkg::OP_STATUS_READ: regs.second_write = 1'b0;
            vsar_pkg::OP_INC_X: begin
               if (v[4:0] == vsar_pkg::COARSE_LAST) begin
                  v[4:0] = '0;
                  v[10]  = ~v[10];
               end else begin
                  v[4:0] = v[4:0] + 5'd1;
               end
            end
            vsar_pkg::OP_INC_Y: begin
               if (v[14:12] != vsar_pkg::FINE_LAST) begin
                  v[14:12] = v[14:12] + 3'd1;
               end else begin
                  v[14:12] = '0;
                  row      = v[9:5];
                  if (row == vsar_pkg::COARSE_Y_ROWEND) begin
                     v[9:5] = '0;
                     v[11]  = ~v[11];
                  end else if (row == vsar_pkg::COARSE_LAST) begin
                     v[9:5] = '0;
                  end else begin
                     v[9:5] = row + 5'd1;
                  end
               end
            end
            vsar_pkg::OP_COPY_H: begin
               v[4:0] = t[4:0];
               v[10]  = t[10];
            end
            vsar_pkg::OP_COPY_V: begin
               v[9:5]   = t[9:5];
               v[14:11] = t[14:11];
            end
            default: ;
         endcase
         regs.current_address   = v;
         regs.temporary_address = t;
      endfunction

      function void note_op(logic [vsar_pkg::OP_WIDTH-1:0] op,
                            logic [vsar_pkg::DATA_WIDTH-1:0] d);
         expected_fetches.push_back(fetch_view());
         apply_op(op, d);
      endfunction

      function void field_check(string name, logic [vsar_pkg::OUT_WIDTH-1:0] want,
                                logic [vsar_pkg::OUT_WIDTH-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_fetch(vsar_pkg::rsp_type got);
         vsar_pkg::rsp_type want;
         if (expected_fetches.size() == 0) begin
            $error("result arrived with no item outstanding");
            failures++;
            return;
         end
         want = expected_fetches.pop_front();
         field_check("vram_address", want.vram_address, got.vram_address);
         field_check("tile_fetch_address", want.tile_fetch_address, got.tile_fetch_address);
         field_check("attribute_fetch_address", want.attribute_fetch_address,
                     got.attribute_fetch_address);
         field_check("attribute_shift", vsar_pkg::OUT_WIDTH'(want.attribute_shift),
                     vsar_pkg::OUT_WIDTH'(got.attribute_shift));
         field_check("fine_y", vsar_pkg::OUT_WIDTH'(want.fine_y),
                     vsar_pkg::OUT_WIDTH'(got.fine_y));
         field_check("fine_x", vsar_pkg::OUT_WIDTH'(want.fine_x),
                     vsar_pkg::OUT_WIDTH'(got.fine_x));
         field_check("write_toggle", vsar_pkg::OUT_WIDTH'(want.write_toggle),
                     vsar_pkg::OUT_WIDTH'(got.write_toggle));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   vsar_req_if req_ch ();
   vsar_rsp_if rsp_ch ();

   video_scroll_address_registers_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   scroll_fetch_scoreboard sb;

   bit          gaps_on     = 1'b0;   // enables gaps on req and stalls on rsp
   int unsigned ops_counted = 0;      // items that act on the registers
   int unsigned rsp_stall   = 0;      // remaining cycles of the current rsp stall
   int unsigned quiet_count = 0;      // cycles since the last handshake

   // 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response side: ready drops in random bursts while gaps are on.
   always @(posedge clock) begin
      if (rsp_stall != 0) begin
         rsp_stall    <= rsp_stall - 1;
         rsp_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_stall    <= $urandom_range(0, 5);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitors sample at the edge, so they see the values that the edge accepts.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_op(req_ch.op, req_ch.data_byte);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_fetch('{rsp_ch.vram_address, rsp_ch.tile_fetch_address,
                          rsp_ch.attribute_fetch_address, rsp_ch.attribute_shift,
                          rsp_ch.fine_y, rsp_ch.fine_x, rsp_ch.write_toggle});
   end

   // Watchdog: a long stretch without any handshake means the block has hung.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
      if (quiet_count >= STALL_LIMIT) begin
         $display("** video_scroll_address_registers_unit: FAILED **");
         $finish;
      end
   end

   function automatic logic [vsar_pkg::DATA_WIDTH-1:0] rand_byte();
      return vsar_pkg::DATA_WIDTH'($urandom);
   endfunction

   // Presents one item and returns at the edge that accepts it.
   // An optional gap comes first.
   task automatic issue_op(input logic [vsar_pkg::OP_WIDTH-1:0] op,
                           input logic [vsar_pkg::DATA_WIDTH-1:0] d);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.data_byte <= d;
      do
         @(posedge clock);
      while (!req_ch.ready);
      if (op < vsar_pkg::OP_NONE)
         ops_counted++;
   endtask

   // A frame-like span: set up scroll through the normal register writes, then
   // walk the render sequence. The row byte is often pushed into the last rows
   // with fine Y at 7, so the vertical wraps come up regularly.
   task automatic run_raster_span();
      logic [vsar_pkg::DATA_WIDTH-1:0] row_byte;
      int unsigned                     span_len;
      int unsigned                     pick;
      issue_op(vsar_pkg::OP_STATUS_READ, rand_byte());
      issue_op(vsar_pkg::OP_CTRL_WRITE, rand_byte());
      issue_op(vsar_pkg::OP_SCROLL_WRITE, rand_byte());
      row_byte = rand_byte();
      if ($urandom_range(0, 1) == 1) begin
         row_byte[7:3] = 5'($urandom_range(27, 31));
         row_byte[2:0] = vsar_pkg::FINE_LAST;
      end
      issue_op(vsar_pkg::OP_SCROLL_WRITE, row_byte);
      if ($urandom_range(0, 3) == 0) begin
         issue_op(vsar_pkg::OP_ADDR_WRITE, rand_byte());
         issue_op(vsar_pkg::OP_ADDR_WRITE, rand_byte());
      end else begin
         issue_op(vsar_pkg::OP_COPY_V, rand_byte());
      end
      issue_op(vsar_pkg::OP_COPY_H, rand_byte());
      span_len = $urandom_range(4, 24);
      repeat (span_len) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: issue_op(vsar_pkg::OP_INC_X, rand_byte());
            4, 5:       issue_op(vsar_pkg::OP_INC_Y, rand_byte());
            6:          issue_op(vsar_pkg::OP_COPY_H, rand_byte());
            7:          issue_op(vsar_pkg::OP_COPY_V, rand_byte());
            default:    issue_op(vsar_pkg::OP_DATA_ACCESS, rand_byte());
         endcase
      end
   endtask

   // Noise: any op code, unused ones too, with any data, in any toggle state.
   task automatic run_noise();
      repeat ($urandom_range(2, 10))
         issue_op(vsar_pkg::OP_WIDTH'($urandom_range(0, 15)), rand_byte());
   endtask

   initial begin
      sb = new();
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.op        <= vsar_pkg::OP_NONE;
      req_ch.data_byte <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no gaps: registers straight out of reset, both increment
      // steps, the coarse X wrap, the row-29 wrap with its nametable flip, the
      // row-31 wrap without flip, the toggle cleared by a status read between
      // address writes, the 14-bit output mask and the 15-bit address wrap.
      issue_op(vsar_pkg::OP_NONE, 8'h00);
      issue_op(vsar_pkg::OP_CTRL_WRITE, 8'hFF);
      issue_op(vsar_pkg::OP_DATA_ACCESS, 8'h00);
      issue_op(vsar_pkg::OP_CTRL_WRITE, 8'h00);
      issue_op(vsar_pkg::OP_DATA_ACCESS, 8'hFF);
      issue_op(vsar_pkg::OP_SCROLL_WRITE, 8'hFF);
      issue_op(vsar_pkg::OP_SCROLL_WRITE, 8'hEF);      // row 29, fine Y 7
      issue_op(vsar_pkg::OP_COPY_H, 8'h00);
      issue_op(vsar_pkg::OP_COPY_V, 8'h00);
      issue_op(vsar_pkg::OP_INC_X, 8'h00);             // coarse X 31 wraps
      issue_op(vsar_pkg::OP_INC_Y, 8'h00);             // row 29 wraps, flips NT Y
      issue_op(vsar_pkg::OP_SCROLL_WRITE, 8'h00);
      issue_op(vsar_pkg::OP_SCROLL_WRITE, 8'hFF);      // row 31, fine Y 7
      issue_op(vsar_pkg::OP_COPY_V, 8'hFF);
      issue_op(vsar_pkg::OP_INC_Y, 8'hFF);             // row 31 wraps, no flip
      issue_op(vsar_pkg::OP_ADDR_WRITE, 8'hFF);
      issue_op(vsar_pkg::OP_STATUS_READ, 8'h00);
      issue_op(vsar_pkg::OP_ADDR_WRITE, 8'h7F);
      issue_op(vsar_pkg::OP_ADDR_WRITE, 8'hFF);        // current becomes 0x3FFF
      issue_op(vsar_pkg::OP_CTRL_WRITE, 8'h07);
      issue_op(vsar_pkg::OP_SCROLL_WRITE, 8'hFF);
      issue_op(vsar_pkg::OP_SCROLL_WRITE, 8'hFF);
      issue_op(vsar_pkg::OP_COPY_H, 8'h00);
      issue_op(vsar_pkg::OP_COPY_V, 8'h00);            // current becomes 0x7FFF
      issue_op(vsar_pkg::OP_DATA_ACCESS, 8'h00);       // +32 wraps past 15 bits
      issue_op(OP_UNUSED_LOW, 8'hFF);
      issue_op(OP_UNUSED_HIGH, 8'hA5);

      // Random part: mostly well-formed spans, some noise. Gaps come and go per
      // span and stop entirely near the end.
      ops_counted = 0;
      while (ops_counted < ITEM_TARGET) begin
         if (ops_counted + CALM_TAIL > ITEM_TARGET)
            gaps_on <= 1'b0;
         else
            gaps_on <= ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 3) == 0)
            run_noise();
         else
            run_raster_span();
      end
      req_ch.valid <= 1'b0;

      while (sb.expected_fetches.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.expected_fetches.size() == 0) begin
         $display("** video_scroll_address_registers_unit: PASSED **");
      end else begin
         $display("** video_scroll_address_registers_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ video_scroll_address_registers_unit.f @@
hdl/vsar_pkg.sv
hdl/vsar_channels.sv
hdl/vsar_update.sv
hdl/video_scroll_address_registers_unit.sv
sim/video_scroll_address_registers_unit_tb.sv
